>>> sv/assert_macros.svh
// Assertion macros shared by the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

>>> sv/cdeq_pkg.sv
// Shared widths, action codes and result item layout of the circular deque.
package cdeq_pkg;

	localparam int WORD_W        = 32;
	localparam int CAP_W         = 5;
	localparam int ACT_W         = 3;
	localparam int CAP_RESET_VAL = 16;

	localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INS_BACK  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DEL_BACK  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_QUERY     = 3'd4;

	// Result item, last field in the lowest bits (72 bits, nine bytes).
	typedef struct packed {
		logic [CAP_W-1:0]         occupancy;
		logic                     is_full;
		logic                     is_empty;
		logic signed [WORD_W-1:0] rear_value;
		logic signed [WORD_W-1:0] front_value;
		logic                     accepted;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

>>> sv/circular_double_ended_queue.sv
// Circular double-ended queue of signed 32-bit words held in a ring memory.
//
// Each input item carries one action in s_tuser (insert front, insert back,
// delete front, delete back, query; unused codes act as query) and the word to
// insert in s_tdata. Inserts are refused when the deque is full and deletes
// when it is empty. Every item yields exactly one result item with the
// accepted flag, the front and rear words after the action (all ones, i.e. -1,
// when empty), the empty and full flags and the occupancy. The words live in a
// ring memory of RING_DEPTH entries with one write port and two registered
// read ports; the pointers and the count live in flip-flops. For each item
// the accept cycle updates the pointers and writes the word, state READ then
// reads the front and rear entries, and state RESP loads the output register.
// Items are taken one at a time: a new item is accepted only after the last
// has loaded the output register, and the result register lets it in while
// the previous result still waits. Writing cfg_wr_data (capacity 1..RING_DEPTH,
// 0 taken as 1, larger values saturated) empties the deque and keeps the memory;
// write it only while the block is idle. No clearing pass runs after reset:
// a read word is only used once an insert has written its entry.
module circular_double_ended_queue #(
	parameter int RING_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input item stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [cdeq_pkg::WORD_W-1:0]         s_tdata,  // [31:0] value
	input  logic [cdeq_pkg::ACT_W-1:0]          s_tuser,  // [2:0] action
	// Result item stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] accepted, [32:1] front_value, [64:33] rear_value, [65] is_empty,
	// [66] is_full, [71:67] occupancy
	output logic [cdeq_pkg::RESULT_W-1:0]       m_tdata,
	// Capacity register write.
	input  logic                                cfg_wr_en,
	input  logic [cdeq_pkg::CAP_W-1:0]          cfg_wr_data
);
	import cdeq_pkg::*;

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int CMP_W = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
	localparam int CAP_RESET_I = (RING_DEPTH < CAP_RESET_VAL) ? RING_DEPTH : CAP_RESET_VAL;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(CAP_RESET_I);
	localparam logic [PTR_W-1:0] TAIL_RESET = PTR_W'(CAP_RESET_I - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	// Saturate a written capacity into 1..RING_DEPTH.
	function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
		logic [CAP_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CAP_W'(1);
		end else if (CMP_W'(v) > CMP_W'(RING_DEPTH)) begin
			r = CAP_W'(RING_DEPTH);
		end
		return r;
	endfunction

	logic [1:0]              state_q;
	logic [CAP_W-1:0]        cap_q;
	logic [PTR_W-1:0]        head_q;
	logic [PTR_W-1:0]        tail_q;
	logic [CAP_W-1:0]        count_q;
	logic                    ok_q;
	logic [WORD_W-1:0]       ring_q [RING_DEPTH];
	logic [WORD_W-1:0]       front_rd_q;
	logic [WORD_W-1:0]       rear_rd_q;
	result_t                 out_q;
	logic                    out_valid_q;

	logic                    in_fire;
	logic                    out_load;
	logic                    full;
	logic                    empty;
	logic [PTR_W-1:0]        cap_last;
	logic [PTR_W-1:0]        head_up;
	logic [PTR_W-1:0]        head_dn;
	logic [PTR_W-1:0]        tail_up;
	logic [PTR_W-1:0]        tail_dn;
	logic [PTR_W-1:0]        head_nx;
	logic [PTR_W-1:0]        tail_nx;
	logic [CAP_W-1:0]        count_nx;
	logic                    ok_nx;
	logic                    wr_en;
	logic [PTR_W-1:0]        wr_addr;
	logic [CAP_W-1:0]        cap_new;
	result_t                 result;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign full     = (count_q >= cap_q);
	assign empty    = (count_q == '0);
	assign cap_last = PTR_W'(cap_q - CAP_W'(1));
	assign cap_new  = clamp_cap(cfg_wr_data);

	// Wrap the pointers at the capacity in use.
	assign head_up = ((CMP_W'(head_q) + CMP_W'(1)) >= CMP_W'(cap_q)) ? '0 : head_q + PTR_W'(1);
	assign tail_up = ((CMP_W'(tail_q) + CMP_W'(1)) >= CMP_W'(cap_q)) ? '0 : tail_q + PTR_W'(1);
	assign head_dn = (head_q == '0) ? cap_last : head_q - PTR_W'(1);
	assign tail_dn = (tail_q == '0) ? cap_last : tail_q - PTR_W'(1);

	// Decode the action against the current fill level.
	always_comb begin
		head_nx  = head_q;
		tail_nx  = tail_q;
		count_nx = count_q;
		ok_nx    = 1'b1;
		wr_en    = 1'b0;
		wr_addr  = head_dn;
		unique case (s_tuser)
			ACT_INS_FRONT: begin
				if (full) begin
					ok_nx = 1'b0;
				end else begin
					head_nx  = head_dn;
					count_nx = count_q + CAP_W'(1);
					wr_en    = 1'b1;
					wr_addr  = head_dn;
				end
			end
			ACT_INS_BACK: begin
				if (full) begin
					ok_nx = 1'b0;
				end else begin
					tail_nx  = tail_up;
					count_nx = count_q + CAP_W'(1);
					wr_en    = 1'b1;
					wr_addr  = tail_up;
				end
			end
			ACT_DEL_FRONT: begin
				if (empty) begin
					ok_nx = 1'b0;
				end else begin
					head_nx  = head_up;
					count_nx = count_q - CAP_W'(1);
				end
			end
			ACT_DEL_BACK: begin
				if (empty) begin
					ok_nx = 1'b0;
				end else begin
					tail_nx  = tail_dn;
					count_nx = count_q - CAP_W'(1);
				end
			end
			default: begin
				// Query and unused codes: leave the state alone.
			end
		endcase
	end

	// Pointer, count and sequencer registers; a capacity write empties the deque.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q   <= CAP_RESET;
			head_q  <= '0;
			tail_q  <= TAIL_RESET;
			count_q <= '0;
			ok_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q   <= cap_new;
				head_q  <= '0;
				tail_q  <= PTR_W'(cap_new - CAP_W'(1));
				count_q <= '0;
			end else if (in_fire) begin
				head_q  <= head_nx;
				tail_q  <= tail_nx;
				count_q <= count_nx;
			end
			if (in_fire) begin
				ok_q <= ok_nx;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Ring memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (in_fire && wr_en) begin
			ring_q[wr_addr] <= s_tdata;
		end
		if (state_q == ST_READ) begin
			front_rd_q <= ring_q[head_q];
			rear_rd_q  <= ring_q[tail_q];
		end
	end

	// Build the result from the updated state and the words just read.
	always_comb begin
		result.accepted    = ok_q;
		result.front_value = empty ? '1 : front_rd_q;
		result.rear_value  = empty ? '1 : rear_rd_q;
		result.is_empty    = empty;
		result.is_full     = full;
		result.occupancy   = count_q;
	end

	// Load the output register when it is free or being drained.
	assign out_load = (state_q == ST_RESP) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

`include "assert_macros.svh"

	`ASSERT_NEVER(a_count_in_cap, clk, arst_n, count_q > cap_q, "count above capacity")
	`ASSERT_NEVER(a_ptr_in_cap, clk, arst_n, (CMP_W'(head_q) >= CMP_W'(cap_q)) || (CMP_W'(tail_q) >= CMP_W'(cap_q)), "pointer beyond capacity")
	`ASSERT_PROP(a_accept_to_resp, clk, arst_n, in_fire |-> ##2 (state_q == ST_RESP), "item did not reach the result stage")
	`ASSERT_PROP(a_empty_result, clk, arst_n, (m_tvalid && out_q.is_empty) |-> ((out_q.occupancy == '0) && (out_q.front_value == '1) && (out_q.rear_value == '1)), "empty result inconsistent")

endmodule
